>>> hw/rtl/dpy_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpy_pkg
// Shared widths, constants, types and helpers for the direction to
// pitch/yaw pipeline.
// ----------------------------------------------------------------------------
package dpy_pkg;

  localparam int COORD_W    = 32;   // Q16.16 coordinate
  localparam int DIFF_W     = 33;   // exact coordinate difference
  localparam int GUARD_BITS = 24;   // pre-scale of the difference
  localparam int XY_W       = 61;   // CORDIC x/y datapath
  localparam int Z_W        = 34;   // Q2.30 angle accumulator
  localparam int ATAN_W     = 30;   // arctangent table entry width
  localparam int MAX_STEPS  = 24;   // table depth
  localparam int GAIN_FRAC  = 30;   // inverse gain fraction bits
  localparam int PITCH_W    = 15;
  localparam int YAW_W      = 16;
  localparam int ANG_W      = 17;   // rounded angle before truncation

  localparam logic signed [Z_W-1:0]   HALF_PI_Q30  = 34'sd1686629713;
  localparam logic [GAIN_FRAC-1:0]    INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [ANG_W-1:0] PITCH_LIMIT  = 17'sd12868;
  localparam logic signed [ANG_W-1:0] YAW_LIMIT    = 17'sd25736;

  // Vector state of one CORDIC step
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  // Carried alongside the yaw pass
  typedef struct packed {
    logic signed [DIFF_W-1:0] ndy;       // pos_y - target_y
    logic                     yaw_zero;  // dx and dz both zero
  } yaw_side_t;

  // Carried through the gain correction
  typedef struct packed {
    logic signed [DIFF_W-1:0] ndy;
    logic signed [YAW_W-1:0]  yaw;
    logic                     pitch_zero;
  } gain_side_t;

  // Carried alongside the pitch pass
  typedef struct packed {
    logic signed [YAW_W-1:0] yaw;
    logic                    pitch_zero;
  } pitch_side_t;

  // atan(2^-i) in Q2.30
  function automatic logic [ATAN_W-1:0] atan_q30(input int idx);
    logic [ATAN_W-1:0] a;
    unique case (idx)
      0:       a = 30'h3243F6A8;
      1:       a = 30'h1DAC6705;
      2:       a = 30'h0FADBAFC;
      3:       a = 30'h07F56EA6;
      4:       a = 30'h03FEAB76;
      5:       a = 30'h01FFD55B;
      6:       a = 30'h00FFFAAA;
      7:       a = 30'h007FFF55;
      8:       a = 30'h003FFFEA;
      9:       a = 30'h001FFFFD;
      10:      a = 30'h000FFFFF;
      11:      a = 30'h0007FFFF;
      12:      a = 30'h0003FFFF;
      13:      a = 30'h0001FFFF;
      14:      a = 30'h0000FFFF;
      15:      a = 30'h00007FFF;
      16:      a = 30'h00003FFF;
      17:      a = 30'h00001FFF;
      18:      a = 30'h00000FFF;
      19:      a = 30'h000007FF;
      20:      a = 30'h000003FF;
      21:      a = 30'h000001FF;
      22:      a = 30'h000000FF;
      23:      a = 30'h0000007F;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Q2.30 to Q2.13, round half up, then clamp to +/- limit
  function automatic logic signed [ANG_W-1:0] round_q13(
    input logic signed [Z_W-1:0]   z,
    input logic signed [ANG_W-1:0] limit
  );
    logic signed [Z_W:0] sum;
    logic signed [Z_W:0] r;
    logic signed [Z_W:0] lim;
    logic signed [ANG_W-1:0] res;
    sum = {z[Z_W-1], z} + 35'sd65536;
    r   = sum >>> 17;
    lim = {{(Z_W+1-ANG_W){limit[ANG_W-1]}}, limit};
    if (r > lim) begin
      res = limit;
    end else if (r < -lim) begin
      res = -limit;
    end else begin
      res = r[ANG_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/dpy_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpy_if
// Valid/ready channels: point pairs in, angle pairs out.
// ----------------------------------------------------------------------------
interface dpy_in_if import dpy_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  logic signed [COORD_W-1:0] target_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, target_x, target_y, target_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, target_x, target_y, target_z,
    output ready
  );
endinterface

interface dpy_out_if import dpy_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PITCH_W-1:0] pitch;
  logic signed [YAW_W-1:0]   yaw;

  modport source (output valid, pitch, yaw, input ready);
  modport sink   (input valid, pitch, yaw, output ready);
endinterface

>>> hw/rtl/dpy_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpy_cordic_stage
// One registered CORDIC vectoring step: rotates toward y = 0 by
// atan(2^-SHIFT) and accumulates the angle. Side data rides along.
// ----------------------------------------------------------------------------
module dpy_cordic_stage import dpy_pkg::*; #(
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  cordic_t           in_data,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output cordic_t           out_data,
  output logic [SIDE_W-1:0] out_side
);

  localparam logic signed [Z_W-1:0] ANGLE =
    $signed({{(Z_W-ATAN_W){1'b0}}, atan_q30(SHIFT)});

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  cordic_t                data_next;

  // Micro-rotation, direction from the sign of y
  always_comb begin
    xs = in_data.x >>> SHIFT;
    ys = in_data.y >>> SHIFT;
    if (!in_data.y[XY_W-1]) begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + ANGLE;
    end else begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
      out_side <= in_side;
    end
  end

endmodule

>>> hw/rtl/dpy_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpy_gain
// Two-stage inverse CORDIC gain: horizontal length from the yaw magnitude,
// multiplied in a high and a low half, then summed with truncation.
// ----------------------------------------------------------------------------
module dpy_gain import dpy_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [XY_W-1:0] mag,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_valid,
  output logic signed [XY_W-1:0] len,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int HI_W = XY_W - GAIN_FRAC;
  localparam int PH_W = HI_W + GAIN_FRAC;
  localparam int PL_W = 2 * GAIN_FRAC;

  logic [XY_W-1:0]      um;
  logic [PH_W-1:0]      prod_hi;
  logic [PL_W-1:0]      prod_lo;
  logic                 mid_valid;
  logic [SIDE_W-1:0]    mid_side;

  // Negative magnitude clamps to zero
  assign um = mag[XY_W-1] ? '0 : mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  // Stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      prod_hi  <= PH_W'(um[XY_W-1:GAIN_FRAC]) * PH_W'(INV_GAIN_Q30);
      prod_lo  <= PL_W'(um[GAIN_FRAC-1:0]) * PL_W'(INV_GAIN_Q30);
      mid_side <= in_side;
    end
  end

  // Stage 2: recombine
  always_ff @(posedge clk) begin
    if (en) begin
      len      <= $signed(prod_hi[XY_W-1:0] +
                          {{(XY_W-GAIN_FRAC){1'b0}}, prod_lo[PL_W-1:GAIN_FRAC]});
      out_side <= mid_side;
    end
  end

endmodule

>>> hw/rtl/direction_to_pitch_yaw_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direction_to_pitch_yaw_top
// Pitch and yaw in Q2.13 radians from a camera position and a look-at point.
// ----------------------------------------------------------------------------
// Fully pipelined: one item enters per cycle while the pipeline moves; each
// result passes the difference register, the quadrant fold, CORDIC_STEPS yaw
// steps, two gain-correction stages, CORDIC_STEPS pitch steps and the output
// register. The pipeline moves as one; it holds only when the output
// register holds an untaken result and the last pitch stage is also full, so
// an item is accepted while a result waits as long as the last pitch stage is empty.
// Yaw is atan2(dx, dz) over the full circle, pitch is atan2(-dy, horizontal
// length); a zero direction gives zero for both.
module direction_to_pitch_yaw_top import dpy_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  dpy_in_if.sink    points,
  dpy_out_if.source angles
);

  localparam int EXT_W   = XY_W - DIFF_W - GUARD_BITS;
  localparam int YSIDE_W = $bits(yaw_side_t);
  localparam int GSIDE_W = $bits(gain_side_t);
  localparam int PSIDE_W = $bits(pitch_side_t);

  logic en;
  logic out_load;

  // Difference stage
  logic                     d_valid;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] ndy;
  logic signed [DIFF_W-1:0] dz;

  // Yaw pass
  logic        yv   [0:CORDIC_STEPS];
  cordic_t     yd   [0:CORDIC_STEPS];
  yaw_side_t   ys   [0:CORDIC_STEPS];

  // Gain correction
  gain_side_t             g_in_side;
  gain_side_t             g_out_side;
  logic                   g_valid;
  logic signed [XY_W-1:0] h;

  // Pitch pass
  logic        pv   [0:CORDIC_STEPS];
  cordic_t     pd   [0:CORDIC_STEPS];
  pitch_side_t ps   [0:CORDIC_STEPS];

  // Output register
  logic                      o_valid;
  logic signed [PITCH_W-1:0] o_pitch;
  logic signed [YAW_W-1:0]   o_yaw;
  logic signed [ANG_W-1:0]   pitch_r;
  logic signed [ANG_W-1:0]   yaw_r;

  // Flow control
  assign out_load     = !o_valid || angles.ready;
  assign en           = out_load || !pv[CORDIC_STEPS];
  assign points.ready = en;

  // Exact 33-bit differences
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= points.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx  <= {points.target_x[COORD_W-1], points.target_x} -
             {points.pos_x[COORD_W-1], points.pos_x};
      ndy <= {points.pos_y[COORD_W-1], points.pos_y} -
             {points.target_y[COORD_W-1], points.target_y};
      dz  <= {points.target_z[COORD_W-1], points.target_z} -
             {points.pos_z[COORD_W-1], points.pos_z};
    end
  end

  // Scale and fold into the right half plane
  logic signed [XY_W-1:0] xsc;
  logic signed [XY_W-1:0] ysc;
  cordic_t                fold;

  assign xsc = {{EXT_W{dz[DIFF_W-1]}}, dz, {GUARD_BITS{1'b0}}};
  assign ysc = {{EXT_W{dx[DIFF_W-1]}}, dx, {GUARD_BITS{1'b0}}};

  always_comb begin
    fold.x = xsc;
    fold.y = ysc;
    fold.z = '0;
    if (dz[DIFF_W-1]) begin
      if (!dx[DIFF_W-1]) begin
        fold.x = ysc;
        fold.y = -xsc;
        fold.z = HALF_PI_Q30;
      end else begin
        fold.x = -ysc;
        fold.y = xsc;
        fold.z = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yv[0] <= 1'b0;
    end else if (en) begin
      yv[0] <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yd[0]          <= fold;
      ys[0].ndy      <= ndy;
      ys[0].yaw_zero <= (dx == '0) && (dz == '0);
    end
  end

  // Yaw CORDIC steps
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_yaw
    dpy_cordic_stage #(
      .SHIFT  (i),
      .SIDE_W (YSIDE_W)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (yv[i]),
      .in_data   (yd[i]),
      .in_side   (ys[i]),
      .out_valid (yv[i+1]),
      .out_data  (yd[i+1]),
      .out_side  (ys[i+1])
    );
  end

  // Yaw rounds here; the magnitude goes on to the gain correction
  assign yaw_r = ys[CORDIC_STEPS].yaw_zero ? '0 :
                 round_q13(yd[CORDIC_STEPS].z, YAW_LIMIT);

  always_comb begin
    g_in_side.ndy        = ys[CORDIC_STEPS].ndy;
    g_in_side.yaw        = yaw_r[YAW_W-1:0];
    g_in_side.pitch_zero = (ys[CORDIC_STEPS].ndy == '0);
  end

  dpy_gain #(
    .SIDE_W (GSIDE_W)
  ) u_gain (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (yv[CORDIC_STEPS]),
    .mag       (yd[CORDIC_STEPS].x),
    .in_side   (g_in_side),
    .out_valid (g_valid),
    .len       (h),
    .out_side  (g_out_side)
  );

  // Pitch pass starts from (h, -dy)
  assign pv[0]            = g_valid;
  assign pd[0].x          = h;
  assign pd[0].y          = {{EXT_W{g_out_side.ndy[DIFF_W-1]}}, g_out_side.ndy,
                             {GUARD_BITS{1'b0}}};
  assign pd[0].z          = '0;
  assign ps[0].yaw        = g_out_side.yaw;
  assign ps[0].pitch_zero = g_out_side.pitch_zero;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pitch
    dpy_cordic_stage #(
      .SHIFT  (i),
      .SIDE_W (PSIDE_W)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (pv[i]),
      .in_data   (pd[i]),
      .in_side   (ps[i]),
      .out_valid (pv[i+1]),
      .out_data  (pd[i+1]),
      .out_side  (ps[i+1])
    );
  end

  // Output register
  assign pitch_r = ps[CORDIC_STEPS].pitch_zero ? '0 :
                   round_q13(pd[CORDIC_STEPS].z, PITCH_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= pv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_pitch <= pitch_r[PITCH_W-1:0];
      o_yaw   <= ps[CORDIC_STEPS].yaw;
    end
  end

  assign angles.valid = o_valid;
  assign angles.pitch = o_pitch;
  assign angles.yaw   = o_yaw;

  // Checks
  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !angles.ready && pv[CORDIC_STEPS]) |-> !points.ready)
    else $error("pipeline advanced into a full output register");

  a_last_moves_out: assert property (@(posedge clk) disable iff (rst)
    (en && pv[CORDIC_STEPS]) |=> o_valid)
    else $error("item left the last stage without reaching the output");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_pitch <= PITCH_LIMIT) && (o_pitch >= -PITCH_LIMIT))
    else $error("pitch outside its range");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_yaw <= YAW_LIMIT) && (o_yaw >= -YAW_LIMIT))
    else $error("yaw outside its range");

endmodule

>>> tb/direction_to_pitch_yaw_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direction_to_pitch_yaw_top_tb
// Drives camera/target point pairs into the pitch/yaw pipeline and checks
// every angle pair against a bit-exact CORDIC predictor kept in the bench.
// Covers zero and vertical directions, all yaw quadrants, coordinate
// extremes, random points with random idling on both channels, a full
// drain pause and a back-to-back stream.
// ----------------------------------------------------------------------------
module direction_to_pitch_yaw_top_tb;
  import dpy_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int LATENCY      = 2 * CORDIC_STEPS + 5;
  localparam int STALL_LIMIT  = 2000;

  localparam longint          QUARTER_TURN_Q30 = 64'sd1686629713;
  localparam longint unsigned INV_GAIN         = 64'd652032874;
  localparam longint          PITCH_MAX_Q13    = 64'sd12868;
  localparam longint          YAW_MAX_Q13      = 64'sd25736;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFFFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;
  localparam logic signed [COORD_W-1:0] ONE       = 32'sh00010000;

  // atan(2^-i) in Q2.30
  localparam longint ARCTAN_Q30 [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
  } point_pair_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch;
    logic signed [YAW_W-1:0]   yaw;
  } angle_pair_t;

  logic clk = 1'b0;
  logic rst;

  dpy_in_if  points ();
  dpy_out_if angles ();

  direction_to_pitch_yaw_top #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .points(points),
    .angles(angles)
  );

  always #2 clk = ~clk;

  angle_pair_t pending_angles[$];
  int          fail_count = 0;
  bit          idle_on    = 1'b1;
  int          quiet_cycles = 0;
  int          stall_left   = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Vectoring CORDIC: angle atan2(y, x) in Q2.30, scaled magnitude in mag
  function automatic longint cordic_vector(input longint x_in, input longint y_in,
                                           output longint mag);
    longint x, y, z, xs, ys, t;
    x = x_in;
    y = y_in;
    z = 0;
    // left half-plane: quarter turn first so the full circle is covered
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = QUARTER_TURN_Q30;
      end else begin
        x = -y;
        y = t;
        z = -QUARTER_TURN_Q30;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_Q30[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_Q30[i];
      end
    end
    mag = x;
    return z;
  endfunction

  // Q2.30 to Q2.13, round half up, clamp
  function automatic longint round_to_q13(input longint a, input longint limit);
    longint r;
    r = (a + 64'sd65536) >>> 17;
    if (r > limit) r = limit;
    if (r < -limit) r = -limit;
    return r;
  endfunction

  function automatic angle_pair_t predict_angles(input point_pair_t p);
    longint          dx, dy, dz, pitch_q30, yaw_q30, mag, mag2, horiz;
    longint unsigned um;
    angle_pair_t     res;
    dx = longint'($signed(p.target_x)) - longint'($signed(p.pos_x));
    dy = longint'($signed(p.target_y)) - longint'($signed(p.pos_y));
    dz = longint'($signed(p.target_z)) - longint'($signed(p.pos_z));
    pitch_q30 = 0;
    yaw_q30   = 0;
    if (dx != 0 || dz != 0) begin
      yaw_q30 = cordic_vector(dz <<< GUARD_BITS, dx <<< GUARD_BITS, mag);
      um = (mag < 0) ? 64'd0 : longint'(mag);
      // horizontal length: magnitude times inverse gain, in two halves
      horiz = longint'((um >> 30) * INV_GAIN +
                       (((um & 64'h3FFFFFFF) * INV_GAIN) >> 30));
      if (dy != 0) pitch_q30 = cordic_vector(horiz, -(dy <<< GUARD_BITS), mag2);
    end else if (dy != 0) begin
      pitch_q30 = cordic_vector(0, -(dy <<< GUARD_BITS), mag2);
    end
    res.pitch = PITCH_W'(round_to_q13(pitch_q30, PITCH_MAX_Q13));
    res.yaw   = YAW_W'(round_to_q13(yaw_q30, YAW_MAX_Q13));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers and result check
  // ---------------------------------------------------------------------------

  // Result side: random stall bursts while idling is on
  always @(posedge clk) begin
    if (rst) begin
      angles.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      angles.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      angles.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 11);
    end else begin
      angles.ready <= 1'b1;
    end
  end

  // Compare each taken result with the oldest prediction
  always @(negedge clk) begin
    angle_pair_t want;
    if (!rst && angles.valid && angles.ready) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected result: pitch %0d yaw %0d", angles.pitch, angles.yaw);
        fail_count++;
      end else begin
        want = pending_angles.pop_front();
        if (angles.pitch !== want.pitch) begin
          $error("pitch mismatch: expected %0d, actual %0d", want.pitch, angles.pitch);
          fail_count++;
        end
        if (angles.yaw !== want.yaw) begin
          $error("yaw mismatch: expected %0d, actual %0d", want.yaw, angles.yaw);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(negedge clk) begin
    if (!rst) begin
      if ((points.valid && points.ready) || (angles.valid && angles.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // Send one item; returns at the edge that accepted it, valid still high
  task automatic send_points(input point_pair_t p);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      points.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    points.valid    <= 1'b1;
    points.pos_x    <= p.pos_x;
    points.pos_y    <= p.pos_y;
    points.pos_z    <= p.pos_z;
    points.target_x <= p.target_x;
    points.target_y <= p.target_y;
    points.target_z <= p.target_z;
    @(negedge clk);
    while (!points.ready) @(negedge clk);
    pending_angles = {pending_angles, predict_angles(p)};
    @(posedge clk);
  endtask

  task automatic hold_points();
    points.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic point_pair_t make_points(
    input logic signed [COORD_W-1:0] px, py, pz, tx, ty, tz
  );
    point_pair_t p;
    p.pos_x    = px;
    p.pos_y    = py;
    p.pos_z    = pz;
    p.target_x = tx;
    p.target_y = ty;
    p.target_z = tz;
    return p;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 4))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Target near the position, each axis independently zero or offset
  function automatic logic signed [COORD_W-1:0] nudge(input logic signed [COORD_W-1:0] c,
                                                      input bit may_zero);
    int span;
    if (may_zero && $urandom_range(0, 2) == 0) return c;
    span = 1 << $urandom_range(0, 24);
    return c + (int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic point_pair_t random_points();
    point_pair_t p;
    p = make_points($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    case ($urandom_range(0, 3))
      0: ;  // fully random coordinates
      1: begin
        p.target_x = nudge(p.pos_x, 1'b0);
        p.target_y = nudge(p.pos_y, 1'b0);
        p.target_z = nudge(p.pos_z, 1'b0);
      end
      2: begin
        p.target_x = nudge(p.pos_x, 1'b1);
        p.target_y = nudge(p.pos_y, 1'b1);
        p.target_z = nudge(p.pos_z, 1'b1);
      end
      default: p = make_points(pick_coord(), pick_coord(), pick_coord(),
                               pick_coord(), pick_coord(), pick_coord());
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero, vertical, axis and quadrant directions, saturation near the poles
  task automatic test_special_directions();
    send_points(make_points(0, 0, 0, 0, 0, 0));
    send_points(make_points(COORD_MAX, COORD_MIN, 5, COORD_MAX, COORD_MIN, 5));
    send_points(make_points(0, 0, 0, 0, ONE, 0));
    send_points(make_points(7, 3, -9, 7, COORD_MIN, -9));
    send_points(make_points(0, 0, 0, 0, 0, ONE));
    send_points(make_points(0, 0, 0, 0, 0, -ONE));
    send_points(make_points(0, 0, 0, ONE, 0, 0));
    send_points(make_points(0, 0, 0, -ONE, 0, 0));
    send_points(make_points(0, 0, 0, ONE, ONE, -ONE));
    send_points(make_points(0, 0, 0, -ONE, -ONE, -ONE));
    // yaw just below zero, close to +pi and close to -pi
    send_points(make_points(0, 0, 0, -1, 0, 32'sh40000000));
    send_points(make_points(0, 0, 0, 1, 0, -32'sh40000000));
    send_points(make_points(0, 0, 32'sh40000000, -1, 0, 0));
    // pitch close to the poles
    send_points(make_points(0, COORD_MIN, 0, 1, COORD_MAX, 0));
    send_points(make_points(0, COORD_MAX, 0, 0, COORD_MIN, 1));
  endtask

  // Largest differences and sign extremes of every field
  task automatic test_field_extremes();
    send_points(make_points(COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MIN, COORD_MIN, COORD_MIN));
    send_points(make_points(COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MAX, COORD_MAX, COORD_MAX));
    send_points(make_points(COORD_MIN, 0, COORD_MAX, '1, COORD_MAX, COORD_MIN));
    send_points(make_points(0, 0, 0, '1, '1, '1));
    send_points(make_points('1, COORD_MAX, 0, COORD_MAX, '1, COORD_MIN));
    send_points(make_points(COORD_MAX, '1, COORD_MIN, 0, COORD_MIN, '1));
  endtask

  task automatic test_random_points(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_points(random_points());
    end
    idle_on = 1'b1;
  endtask

  // Sender stops until the pipeline has delivered everything
  task automatic test_drain_pause();
    for (int n = 0; n < 10; n++) send_points(random_points());
    hold_points();
    while (pending_angles.size() != 0) @(posedge clk);
    for (int n = 0; n < 10; n++) send_points(random_points());
  endtask

  // No idling on either side: one item per cycle
  task automatic test_streaming(input int count);
    idle_on = 1'b0;
    for (int n = 0; n < count; n++) send_points(random_points());
  endtask

  initial begin
    rst             <= 1'b1;
    points.valid    <= 1'b0;
    points.pos_x    <= '0;
    points.pos_y    <= '0;
    points.pos_z    <= '0;
    points.target_x <= '0;
    points.target_y <= '0;
    points.target_z <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_special_directions();
    test_field_extremes();
    test_random_points(480);
    test_drain_pause();
    test_streaming(80);

    hold_points();
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/dpy_pkg.sv
hw/rtl/dpy_if.sv
hw/rtl/dpy_cordic_stage.sv
hw/rtl/dpy_gain.sv
hw/rtl/direction_to_pitch_yaw_top.sv
tb/direction_to_pitch_yaw_top_tb.sv
